FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the S.BUS decoder modules.
// No dependencies; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When pre holds, post must hold at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/core/sfd_pkg.sv
// Shared types and constants for the S.BUS frame decoder.
// No dependencies; used by sfd_ctrl, sfd_datapath and sbus_frame_decoder.
package sfd_pkg;

   localparam int FRAME_BYTES     = 25;
   localparam int FRAME_W         = FRAME_BYTES * 8;
   localparam int RAW_W           = 11;
   localparam int ANALOG_CHANNELS = 16;
   localparam int NUM_CHANNELS    = 18;
   localparam int CHAN_W          = 5;
   localparam int VALUE_W         = 12;
   localparam int MID_W           = 11;
   localparam int CSR_ADDR_W      = 1;
   localparam int CSR_DATA_W      = 12;
   localparam int REQ_DATA_W      = 8;
   localparam int RSP_DATA_W      = 24;

   localparam logic [7:0] SYNC_BYTE = 8'h0F;

   localparam logic [CHAN_W-1:0] FIRST_CHANNEL    = CHAN_W'(0);
   localparam logic [CHAN_W-1:0] DIGITAL_CHANNEL0 = CHAN_W'(ANALOG_CHANNELS);
   localparam logic [CHAN_W-1:0] DIGITAL_CHANNEL1 = CHAN_W'(ANALOG_CHANNELS + 1);
   localparam logic [CHAN_W-1:0] LAST_CHANNEL     = CHAN_W'(NUM_CHANNELS - 1);
   localparam logic [CHAN_W-1:0] LAST_BYTE_POS    = CHAN_W'(FRAME_BYTES - 1);
   localparam logic [CHAN_W-1:0] POS_AFTER_SYNC   = CHAN_W'(1);

   localparam logic [VALUE_W-1:0] DIGITAL_HIGH = VALUE_W'(2000);
   localparam logic [VALUE_W-1:0] DIGITAL_LOW  = VALUE_W'(1000);
   localparam logic [VALUE_W-1:0] VALUE_MAX    = VALUE_W'(4095);

   localparam logic [MID_W-1:0]   MID_OFFSET_RESET   = MID_W'(988);
   localparam logic [VALUE_W-1:0] CENTER_VALUE_RESET = VALUE_W'(1500);

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_W-1:0] CSR_MID_OFFSET   = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_VALUE = 1'b1;

   // Flag byte bit positions
   localparam int FLAG_FAILSAFE_BIT = 3;
   localparam int FLAG_BYTE_LSB     = 23 * 8;

   typedef enum logic [2:0] {
      ST_HUNT = 3'b001,
      ST_FILL = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic              shift_byte;
      logic              issue;
      logic [CHAN_W-1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic sync_byte;
      logic advance;
   } status_type;

endpackage

FILE: rtl/core/sbus_frame_decoder.sv
// S.BUS frame decoder. Bytes other than 0x0F are dropped until a sync byte
// opens a frame; the next 24 bytes are taken into a 200-bit frame shift
// register. After the 25th byte the input stalls while a single shared
// decode unit issues one channel per cycle, shifting the frame right by one
// 11-bit field per analog channel; rsp_tready backpressure stalls channel
// issue. Results pass from issue through a decode stage and an output
// register.
// Depends on sfd_pkg, sfd_ctrl and sfd_datapath.
module sbus_frame_decoder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sfd_pkg::REQ_DATA_W-1:0]    req_tdata,   // [7:0] rx_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sfd_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [4:0] channel_index,
                                                          // [16:5] channel_value,
                                                          // [23:17] zero
   output logic                              rsp_tuser,   // [0] failsafe_active
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   sfd_pkg::cmd_type    cmd;
   sfd_pkg::status_type status;

   sfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sfd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/core/sfd_ctrl.sv
// Controller for the S.BUS frame decoder: sync hunt, byte count, channel issue.
// Depends on sfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  sfd_pkg::status_type    status,
   output sfd_pkg::cmd_type       cmd
);

   sfd_pkg::state_type            state_ff, state_in;
   logic [sfd_pkg::CHAN_W-1:0]    pos_ff, pos_in;
   logic [sfd_pkg::CHAN_W-1:0]    chan_ff, chan_in;
   logic                          accept;

   assign req_tready = (state_ff != sfd_pkg::ST_EMIT);
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      chan_in        = chan_ff;
      cmd.shift_byte = 1'b0;
      cmd.issue      = 1'b0;
      cmd.chan       = chan_ff;
      case (state_ff)
         sfd_pkg::ST_HUNT: begin
            // drop everything but the sync byte
            if (accept && status.sync_byte) begin
               cmd.shift_byte = 1'b1;
               pos_in         = sfd_pkg::POS_AFTER_SYNC;
               state_in       = sfd_pkg::ST_FILL;
            end
         end
         sfd_pkg::ST_FILL: begin
            if (accept) begin
               cmd.shift_byte = 1'b1;
               if (pos_ff == sfd_pkg::LAST_BYTE_POS) begin
                  chan_in  = sfd_pkg::FIRST_CHANNEL;
                  state_in = sfd_pkg::ST_EMIT;
               end else begin
                  pos_in = pos_ff + sfd_pkg::CHAN_W'(1);
               end
            end
         end
         sfd_pkg::ST_EMIT: begin
            if (status.advance) begin
               cmd.issue = 1'b1;
               if (chan_ff == sfd_pkg::LAST_CHANNEL) begin
                  state_in = sfd_pkg::ST_HUNT;
               end else begin
                  chan_in = chan_ff + sfd_pkg::CHAN_W'(1);
               end
            end
         end
         default: begin
            state_in = sfd_pkg::ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfd_pkg::ST_HUNT;
         pos_ff   <= '0;
         chan_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         chan_ff  <= chan_in;
      end
   end

   `ASSERT_ALWAYS(a_chan_range, clock, reset,
      (state_ff != sfd_pkg::ST_EMIT) || (chan_ff <= sfd_pkg::LAST_CHANNEL),
      "channel counter beyond last channel")
   `ASSERT_ALWAYS(a_pos_range, clock, reset,
      (state_ff != sfd_pkg::ST_FILL) || (pos_ff <= sfd_pkg::LAST_BYTE_POS),
      "byte position beyond frame end")
   `ASSERT_NEXT(a_last_to_hunt, clock, reset,
      cmd.issue && (cmd.chan == sfd_pkg::LAST_CHANNEL),
      state_ff == sfd_pkg::ST_HUNT,
      "controller did not return to hunt after last channel")
   `ASSERT_NEXT(a_fill_to_emit, clock, reset,
      (state_ff == sfd_pkg::ST_FILL) && accept && (pos_ff == sfd_pkg::LAST_BYTE_POS),
      (state_ff == sfd_pkg::ST_EMIT) && (chan_ff == sfd_pkg::FIRST_CHANNEL),
      "frame end did not start channel issue at channel 0")

endmodule

FILE: rtl/core/sfd_datapath.sv
// Datapath for the S.BUS frame decoder: frame shift register, config registers,
// channel decode stage and output register. Depends on sfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [sfd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              csr_we,
   input  logic [sfd_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  sfd_pkg::cmd_type                  cmd,
   output sfd_pkg::status_type               status,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sfd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);

   localparam int PAD_W = sfd_pkg::RSP_DATA_W - sfd_pkg::CHAN_W - sfd_pkg::VALUE_W;

   logic [sfd_pkg::MID_W-1:0]     mid_ff;
   logic [sfd_pkg::VALUE_W-1:0]   center_ff;
   logic [sfd_pkg::FRAME_W-1:0]   frame_ff, frame_in;
   logic [7:0]                    flags_ff, flags_in;

   // decode stage
   logic                          s1_valid_ff, s1_valid_in;
   logic [sfd_pkg::CHAN_W-1:0]    s1_chan_ff;
   logic [sfd_pkg::VALUE_W-1:0]   s1_value_ff;
   logic                          s1_analog_ff;
   logic                          s1_fs_ff;

   // output register
   logic                          out_valid_ff, out_valid_in;
   logic [sfd_pkg::CHAN_W-1:0]    out_chan_ff;
   logic [sfd_pkg::VALUE_W-1:0]   out_value_ff, out_value_in;
   logic                          out_fs_ff;

   logic                          advance;
   logic                          is_analog;
   logic                          is_first;
   logic [sfd_pkg::RAW_W-1:0]     raw;
   logic [sfd_pkg::VALUE_W-1:0]   halved_sum;
   logic                          digital_bit;
   logic                          fs_now;
   logic [sfd_pkg::VALUE_W-1:0]   span;
   logic [sfd_pkg::VALUE_W:0]     stretched;

   assign advance          = !out_valid_ff || rsp_tready;
   assign status.advance   = advance;
   assign status.sync_byte = (req_tdata == sfd_pkg::SYNC_BYTE);

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff    <= sfd_pkg::MID_OFFSET_RESET;
         center_ff <= sfd_pkg::CENTER_VALUE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            sfd_pkg::CSR_MID_OFFSET:   mid_ff    <= csr_wdata[sfd_pkg::MID_W-1:0];
            sfd_pkg::CSR_CENTER_VALUE: center_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign is_analog = (cmd.chan < sfd_pkg::DIGITAL_CHANNEL0);
   assign is_first  = (cmd.chan == sfd_pkg::FIRST_CHANNEL);
   // channel c sits just above the sync byte once c fields have been shifted out
   assign raw        = frame_ff[8 +: sfd_pkg::RAW_W];
   assign halved_sum = sfd_pkg::VALUE_W'(raw[sfd_pkg::RAW_W-1:1]) +
                       sfd_pkg::VALUE_W'(mid_ff);
   assign fs_now     = is_first ? frame_ff[sfd_pkg::FLAG_BYTE_LSB + sfd_pkg::FLAG_FAILSAFE_BIT]
                                : flags_ff[sfd_pkg::FLAG_FAILSAFE_BIT];
   assign digital_bit = (cmd.chan == sfd_pkg::DIGITAL_CHANNEL1) ? flags_ff[1] : flags_ff[0];

   always_comb begin
      frame_in = frame_ff;
      flags_in = flags_ff;
      if (cmd.shift_byte) begin
         // new byte enters at the top; after a full frame byte 0 sits lowest
         frame_in = {req_tdata, frame_ff[sfd_pkg::FRAME_W-1:8]};
      end else if (cmd.issue && is_analog) begin
         frame_in = frame_ff >> sfd_pkg::RAW_W;
      end
      if (cmd.issue && is_first) begin
         flags_in = frame_ff[sfd_pkg::FLAG_BYTE_LSB +: 8];
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      flags_ff <= flags_in;
   end

   assign s1_valid_in = advance ? cmd.issue : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_chan_ff   <= cmd.chan;
         s1_analog_ff <= is_analog;
         s1_fs_ff     <= fs_now;
         if (is_analog) begin
            s1_value_ff <= halved_sum;
         end else begin
            s1_value_ff <= digital_bit ? sfd_pkg::DIGITAL_HIGH : sfd_pkg::DIGITAL_LOW;
         end
      end
   end

   // quarter stretch of analog values about the centre, saturated to the value range
   always_comb begin
      stretched = '0;
      if (s1_value_ff < center_ff) begin
         span      = center_ff - s1_value_ff;
         stretched = {1'b0, s1_value_ff} - {3'b000, span[sfd_pkg::VALUE_W-1:2]};
         if (span[sfd_pkg::VALUE_W-1:2] > s1_value_ff) begin
            stretched = '0;
         end
      end else begin
         span      = s1_value_ff - center_ff;
         stretched = {1'b0, s1_value_ff} + {3'b000, span[sfd_pkg::VALUE_W-1:2]};
      end
      if (!s1_analog_ff) begin
         out_value_in = s1_value_ff;
      end else if (stretched[sfd_pkg::VALUE_W]) begin
         out_value_in = sfd_pkg::VALUE_MAX;
      end else begin
         out_value_in = stretched[sfd_pkg::VALUE_W-1:0];
      end
   end

   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_chan_ff  <= s1_chan_ff;
         out_value_ff <= out_value_in;
         out_fs_ff    <= s1_fs_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_value_ff, out_chan_ff};
   assign rsp_tuser  = out_fs_ff;
   assign rsp_tlast  = (out_chan_ff == sfd_pkg::LAST_CHANNEL);

   `ASSERT_ALWAYS(a_digital_value, clock, reset,
      !out_valid_ff || (out_chan_ff < sfd_pkg::DIGITAL_CHANNEL0) ||
      (out_value_ff == sfd_pkg::DIGITAL_HIGH) || (out_value_ff == sfd_pkg::DIGITAL_LOW),
      "digital channel value is neither high nor low")
   `ASSERT_NEXT(a_issue_fills_stage, clock, reset,
      cmd.issue,
      s1_valid_ff,
      "issued channel did not enter the decode stage")
   `ASSERT_ALWAYS(a_no_shift_while_issue, clock, reset,
      !(cmd.issue && cmd.shift_byte),
      "byte shift and channel issue in the same cycle")

endmodule
